@@ hdl/ssp_pkg.sv @@
// Types and constants shared by the servo status packet parser.
`timescale 1ns / 1ps
package ssp_pkg;

   localparam logic [7:0] HEADER_BYTE    = 8'hFF;
   localparam logic [7:0] FRAME_OVERHEAD = 8'd6;
   localparam logic [7:0] PAYLOAD_OFFSET = 8'd5;
   localparam logic [7:0] PAYLOAD_MAX    = 8'd250;
   localparam logic [7:0] ID_POSITION    = 8'd2;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_HEADER   = 2'd1,
      ERR_ID       = 2'd2,
      ERR_CHECKSUM = 2'd3
   } err_type;

   typedef enum logic {
      REG_EXPECTED_ID    = 1'b0,
      REG_PAYLOAD_LENGTH = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic       payload_valid;
      logic [7:0] payload_byte;
      logic       payload_last;
      logic       frame_done;
      logic       frame_ok;
      logic [1:0] error_code;
   } rsp_type;

   typedef struct packed {
      logic [7:0] expected_id;
      logic [7:0] payload_length;
   } cfg_type;

endpackage

@@ hdl/servo_status_packet_parser_unit.sv @@
// Top level of the servo status packet parser.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_data (rx_byte, frame_start)
//   rsp      out        rsp_valid/rsp_stall  rsp_data (payload and frame status)
//   csr      in         csr_wr_en            csr_index, csr_wdata
//
// One registered result per item; an item every cycle unless req_stall is high.
// The frame state updates on the accepting edge; the result register holds it.
// req_stall rises only while a held result is stalled.
// Reset clears the frame state, the result valid and the registers to defaults.
`timescale 1ns / 1ps
module servo_status_packet_parser_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ssp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ssp_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic             csr_index,
   input  logic [7:0]       csr_wdata
);
   import ssp_pkg::*;

   cfg_type cfg;
   rsp_type rsp_next;
   logic    accept;
   logic    busy;

   assign req_stall = busy;
   assign accept    = req_valid && !busy;

   ssp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ssp_frame u_frame (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .cfg    (cfg),
      .rsp    (rsp_next)
   );

   ssp_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .rsp_next  (rsp_next),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .busy      (busy)
   );

endmodule

@@ hdl/ssp_csr.sv @@
// Configuration registers of the servo status packet parser.
`timescale 1ns / 1ps
module ssp_csr (
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_wr_en,
   input  logic           csr_index,
   input  logic [7:0]     csr_wdata,
   output ssp_pkg::cfg_type cfg
);
   import ssp_pkg::*;

   logic [7:0] expected_id_ff, expected_id_in;
   logic [7:0] payload_length_ff, payload_length_in;

   always_comb begin
      expected_id_in    = expected_id_ff;
      payload_length_in = payload_length_ff;
      if (csr_wr_en) begin
         case (reg_index_type'(csr_index))
            REG_EXPECTED_ID:    expected_id_in    = csr_wdata;
            REG_PAYLOAD_LENGTH: payload_length_in = csr_wdata;
            default:            expected_id_in    = expected_id_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_id_ff    <= 8'd0;
         payload_length_ff <= 8'd2;
      end else begin
         expected_id_ff    <= expected_id_in;
         payload_length_ff <= payload_length_in;
      end
   end

   assign cfg.expected_id    = expected_id_ff;
   assign cfg.payload_length = payload_length_ff;

endmodule

@@ hdl/ssp_frame.sv @@
// Frame tracking state and per-byte result logic.
`timescale 1ns / 1ps
module ssp_frame (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  ssp_pkg::req_type req,
   input  ssp_pkg::cfg_type cfg,
   output ssp_pkg::rsp_type rsp
);
   import ssp_pkg::*;

   logic [7:0] pos_ff, pos_in;
   logic [7:0] sum_ff, sum_in;
   err_type    err_ff, err_in;

   logic [7:0] len;
   logic [7:0] last;
   logic [7:0] pos;
   logic [7:0] sum;
   err_type    err;
   logic [7:0] b;

   always_comb begin
      b    = req.rx_byte;
      len  = (cfg.payload_length > PAYLOAD_MAX) ? PAYLOAD_MAX : cfg.payload_length;
      last = len + FRAME_OVERHEAD - 8'd1;
      pos  = req.frame_start ? 8'd0 : pos_ff;
      sum  = req.frame_start ? 8'd0 : sum_ff;
      err  = req.frame_start ? ERR_NONE : err_ff;

      pos_in = pos;
      sum_in = sum;
      err_in = err;
      rsp    = '0;

      if (pos >= last) begin
         // checksum byte closes the frame
         if ((~sum != b) && (err == ERR_NONE)) err_in = ERR_CHECKSUM;
         rsp.frame_done = 1'b1;
         rsp.error_code = err_in;
         rsp.frame_ok   = (err_in == ERR_NONE);
         pos_in = 8'd0;
         sum_in = 8'd0;
         err_in = ERR_NONE;
      end else begin
         if (pos < ID_POSITION) begin
            if ((b != HEADER_BYTE) && (err == ERR_NONE)) err_in = ERR_HEADER;
         end else begin
            sum_in = sum + b;
            if ((pos == ID_POSITION) && (b != cfg.expected_id) && (err == ERR_NONE))
               err_in = ERR_ID;
            if (pos >= PAYLOAD_OFFSET) begin
               rsp.payload_valid = 1'b1;
               rsp.payload_byte  = b;
               rsp.payload_last  = (pos == last - 8'd1);
            end
         end
         pos_in = pos + 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 8'd0;
         sum_ff <= 8'd0;
         err_ff <= ERR_NONE;
      end else if (accept) begin
         pos_ff <= pos_in;
         sum_ff <= sum_in;
         err_ff <= err_in;
      end
   end

   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && rsp.frame_done) |=> (pos_ff == 8'd0 && sum_ff == 8'd0 && err_ff == ERR_NONE))
      else $error("frame state not cleared after checksum byte");

   a_ok_no_error: assert property (@(posedge clock) disable iff (reset)
      rsp.frame_ok |-> (rsp.frame_done && rsp.error_code == ERR_NONE))
      else $error("frame_ok with an error code");

   a_payload_not_done: assert property (@(posedge clock) disable iff (reset)
      rsp.payload_valid |-> !rsp.frame_done)
      else $error("payload byte flagged on checksum byte");

endmodule

@@ hdl/ssp_out_reg.sv @@
// Result register between the parser logic and the result channel.
`timescale 1ns / 1ps
module ssp_out_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  ssp_pkg::rsp_type rsp_next,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output ssp_pkg::rsp_type rsp_data,
   output logic             busy
);
   import ssp_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   always_comb begin
      valid_in = valid_ff && rsp_stall;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = rsp_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;
   assign busy      = valid_ff && rsp_stall;

   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rsp_stall) |=> (valid_ff && !$past(load)))
      else $error("item loaded over a stalled result");

endmodule
